// ===== src/rrw_pkg.sv =====
package rrw_pkg;

  localparam int DEF_MAX_JOBS = 16;
  localparam int TICK_W       = 16;
  localparam int TIME_W       = 24;
  localparam int SUM_W        = 32;
  localparam int IDX_W        = 6;

  localparam logic [TICK_W-1:0] QUANTUM_RESET = 16'd1;

  localparam logic KIND_JOB   = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_EXEC,
    ST_PASS,
    ST_TOTAL
  } rrw_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic rd;
    logic exec;
    logic pass_end;
    logic emit_total;
  } rrw_cmd_t;

  typedef struct packed {
    logic batch_full;
    logic ex_emit;
    logic out_busy;
    logic i_last;
    logic all_done;
  } rrw_sts_t;

endpackage

// ===== src/rrw_job_if.sv =====
interface rrw_job_if;
  logic        valid;
  logic        ready;
  logic [15:0] arrival_tick;
  logic [15:0] burst_ticks;
  logic        last_job;

  modport source (output valid, arrival_tick, burst_ticks, last_job, input ready);
  modport sink   (input valid, arrival_tick, burst_ticks, last_job, output ready);
endinterface

// ===== src/rrw_result_if.sv =====
interface rrw_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [5:0]  job_index;
  logic [23:0] finish_tick;
  logic [31:0] total_waiting;
  logic [31:0] total_turnaround;
  logic        last_result;

  modport source (output valid, result_kind, job_index, finish_tick, total_waiting,
                  total_turnaround, last_result, input ready);
  modport sink   (input valid, result_kind, job_index, finish_tick, total_waiting,
                  total_turnaround, last_result, output ready);
endinterface

// ===== src/round_robin_wait_time_sim.sv =====
// Job records transfer one per cycle while loading; a record without last_job is absorbed.
// After the record with last_job, each pass visits every loaded job in turn (entry read,
// then execute) and then closes the pass; when a whole pass finds every job finished,
// the totals record follows.
// Each result sits in an output register; a new result waits while that register is full.
// Synchronous reset empties the batch and sets the quantum to 1.
module round_robin_wait_time_sim #(
  parameter int MAX_JOBS = rrw_pkg::DEF_MAX_JOBS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       time_quantum_we,
  input  logic [rrw_pkg::TICK_W-1:0] time_quantum_wdata,
  rrw_job_if.sink                    in_job,
  rrw_result_if.source               out_result
);
  import rrw_pkg::*;

  rrw_cmd_t cmd;
  rrw_sts_t sts;

  rrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_job.valid),
    .in_last  (in_job.last_job),
    .in_ready (in_job.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrw_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_arrival    (in_job.arrival_tick),
    .in_burst      (in_job.burst_ticks),
    .quantum_we    (time_quantum_we),
    .quantum_wdata (time_quantum_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .res           (out_result)
  );

endmodule

// ===== src/rrw_ctrl.sv =====
module rrw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  rrw_pkg::rrw_sts_t sts,
  output rrw_pkg::rrw_cmd_t cmd
);
  import rrw_pkg::*;

  rrw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        // refuse transfers while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = !sts.batch_full;
          if (in_last) begin
            cmd.start  = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // hold while a completion record has nowhere to go
        if (!(sts.ex_emit && sts.out_busy)) begin
          cmd.exec   = 1'b1;
          state_next = sts.i_last ? ST_PASS : ST_READ;
        end
      end
      ST_PASS: begin
        cmd.pass_end = 1'b1;
        state_next   = sts.all_done ? ST_TOTAL : ST_READ;
      end
      ST_TOTAL: begin
        if (!sts.out_busy) begin
          cmd.emit_total = 1'b1;
          state_next     = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

// ===== src/rrw_dp.sv =====
module rrw_dp #(
  parameter int MAX_JOBS = rrw_pkg::DEF_MAX_JOBS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rrw_pkg::TICK_W-1:0]  in_arrival,
  input  logic [rrw_pkg::TICK_W-1:0]  in_burst,
  input  logic                        quantum_we,
  input  logic [rrw_pkg::TICK_W-1:0]  quantum_wdata,
  input  rrw_pkg::rrw_cmd_t           cmd,
  output rrw_pkg::rrw_sts_t           sts,
  rrw_result_if.source                res
);
  import rrw_pkg::*;

  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int IW = $clog2(MAX_JOBS);

  logic [TICK_W-1:0] arr_q   [MAX_JOBS];
  logic [TICK_W-1:0] burst_q [MAX_JOBS];
  logic [TICK_W-1:0] done_q  [MAX_JOBS];
  logic [IDX_W-1:0]  lidx_q  [MAX_JOBS];

  logic [CW-1:0]     count;
  logic [IW-1:0]     i;
  logic [TIME_W-1:0] sim_time;
  logic [SUM_W-1:0]  wait_sum;
  logic [SUM_W-1:0]  burst_sum;
  logic              ran;
  logic              all_cmp;
  logic [TICK_W-1:0] quantum;

  logic [TICK_W-1:0] rd_arr, rd_burst, rd_done;
  logic [IDX_W-1:0]  rd_lidx;

  logic [MAX_JOBS-1:0] gt, take_prev, take_new;

  logic [TICK_W-1:0] q_eff, rem;
  logic              arrived, fin, fits, runs;
  logic [TIME_W-1:0] wait_inc;

  // sorted by arrival: later arrivals form a suffix that moves up one slot
  always_comb begin
    for (int k = 0; k < MAX_JOBS; k++) begin
      gt[k] = (CW'(k) < count) && (arr_q[k] > in_arrival);
    end
    for (int k = 0; k < MAX_JOBS; k++) begin
      take_prev[k] = (k > 0) ? gt[(k > 0) ? k - 1 : 0] : 1'b0;
      take_new[k]  = !take_prev[k] && ((CW'(k) == count) || gt[k]);
    end
  end

  assign q_eff    = (quantum == '0) ? TICK_W'(1) : quantum;
  assign arrived  = sim_time >= TIME_W'(rd_arr);
  assign fin      = rd_done == rd_burst;
  assign rem      = rd_burst - rd_done;
  assign fits     = rem <= q_eff;
  assign runs     = arrived && !fin;
  assign wait_inc = sim_time - TIME_W'(rd_done) - TIME_W'(rd_arr);

  assign sts.batch_full = count == CW'(MAX_JOBS);
  assign sts.ex_emit    = runs && fits;
  assign sts.out_busy   = res.valid && !res.ready;
  assign sts.i_last     = CW'(i) == count - CW'(1);
  assign sts.all_done   = all_cmp;

  generate
    for (genvar k = 0; k < MAX_JOBS; k++) begin : g_slot
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          if (take_prev[k]) begin
            arr_q[k]   <= arr_q[(k > 0) ? k - 1 : 0];
            burst_q[k] <= burst_q[(k > 0) ? k - 1 : 0];
            done_q[k]  <= done_q[(k > 0) ? k - 1 : 0];
            lidx_q[k]  <= lidx_q[(k > 0) ? k - 1 : 0];
          end else if (take_new[k]) begin
            arr_q[k]   <= in_arrival;
            burst_q[k] <= in_burst;
            done_q[k]  <= '0;
            lidx_q[k]  <= IDX_W'(count);
          end
        end else if (cmd.exec && runs && (i == IW'(k))) begin
          done_q[k] <= fits ? rd_burst : rd_done + q_eff;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_arr   <= arr_q[i];
      rd_burst <= burst_q[i];
      rd_done  <= done_q[i];
      rd_lidx  <= lidx_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (quantum_we) begin
      quantum <= quantum_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      i         <= '0;
      sim_time  <= '0;
      wait_sum  <= '0;
      burst_sum <= '0;
      ran       <= 1'b0;
      all_cmp   <= 1'b1;
      res.valid <= 1'b0;
    end else begin
      if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (cmd.load) begin
        count     <= count + CW'(1);
        burst_sum <= ((count == '0) ? '0 : burst_sum) + SUM_W'(in_burst);
      end
      if (cmd.start) begin
        i        <= '0;
        sim_time <= '0;
        wait_sum <= '0;
        ran      <= 1'b0;
        all_cmp  <= 1'b1;
      end
      if (cmd.exec) begin
        i <= i + IW'(1);
        if (!(arrived && fin)) begin
          all_cmp <= 1'b0;
        end
        if (runs) begin
          ran <= 1'b1;
          if (fits) begin
            wait_sum             <= wait_sum + SUM_W'(wait_inc);
            sim_time             <= sim_time + TIME_W'(rem);
            res.valid            <= 1'b1;
            res.result_kind      <= KIND_JOB;
            res.job_index        <= rd_lidx;
            res.finish_tick      <= sim_time + TIME_W'(rem);
            res.total_waiting    <= '0;
            res.total_turnaround <= '0;
            res.last_result      <= 1'b0;
          end else begin
            sim_time <= sim_time + TIME_W'(q_eff);
          end
        end
      end
      if (cmd.pass_end) begin
        // an idle pass lets the clock tick once
        if (!ran) begin
          sim_time <= sim_time + TIME_W'(1);
        end
        i       <= '0;
        ran     <= 1'b0;
        all_cmp <= 1'b1;
      end
      if (cmd.emit_total) begin
        count                <= '0;
        res.valid            <= 1'b1;
        res.result_kind      <= KIND_TOTAL;
        res.job_index        <= '0;
        res.finish_tick      <= '0;
        res.total_waiting    <= wait_sum;
        res.total_turnaround <= wait_sum + burst_sum;
        res.last_result      <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> count == $past(count) + CW'(1))
    else $error("job count did not advance on load");

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> rd_done <= rd_burst)
    else $error("job ran past its burst");

  a_total_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_total |-> !sts.out_busy)
    else $error("totals record would overwrite a pending result");

  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> sim_time >= $past(sim_time))
    else $error("simulated time went backward");
`endif

endmodule
